[rtl/core/pfd_pkg.sv]
// Shared types, constants and helper functions for the Playfair decryption block.
package pfd_pkg;

  localparam int SIDE = 5;
  localparam int CELLS = SIDE * SIDE;
  localparam int LETTERS = 26;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_Z = 5'd25;
  localparam logic [4:0] CELL_COUNT = 5'(CELLS);
  localparam logic [2:0] LAST_ROW = 3'(SIDE - 1);

  localparam logic [1:0] OP_KEY = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_DECRYPT = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef enum logic [1:0] {
    CMD_KEY,
    CMD_FINISH,
    CMD_DECRYPT,
    CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] first_letter;
    logic [4:0] second_letter;
  } in_word_t;

  typedef struct packed {
    logic [4:0] plain_first;
    logic [4:0] plain_second;
  } out_word_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [4:0] a;
    logic [4:0] b;
  } cmd_word_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  // Fold J onto I.
  function automatic logic [4:0] fold_j(input logic [4:0] l);
    return (l == LETTER_J) ? LETTER_I : l;
  endfunction

  // Clamp a cipher letter to Z, then fold J onto I.
  function automatic logic [4:0] cipher_letter(input logic [4:0] l);
    return fold_j((l > LETTER_Z) ? LETTER_Z : l);
  endfunction

  // Row of a cell index below 25.
  function automatic logic [2:0] cell_row(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  // Row times five.
  function automatic logic [4:0] row_base(input logic [2:0] r);
    return {r[2:0], 2'b00} + {2'b00, r};
  endfunction

  // Column of a cell index below 25.
  function automatic logic [2:0] cell_col(input logic [4:0] p);
    logic [4:0] d;
    d = p - row_base(cell_row(p));
    return d[2:0];
  endfunction

  function automatic logic [4:0] cell_index(input logic [2:0] r, input logic [2:0] c);
    return row_base(r) + {2'b00, c};
  endfunction

  // Step one place back with wrap.
  function automatic logic [2:0] step_back(input logic [2:0] v);
    return (v == 3'd0) ? LAST_ROW : v - 3'd1;
  endfunction

endpackage

[rtl/core/pfd_front.sv]
// Front end: accepts input words and turns them into queued commands.
module pfd_front
  import pfd_pkg::*;
(
  input  logic      start,
  input  in_word_t  item,
  input  q_stat_t   q_stat,
  output logic      busy,
  output logic      push,
  output cmd_word_t entry
);

  logic accept;

  assign busy = q_stat.full;
  assign accept = start && !q_stat.full;

  always_comb begin
    entry.a = cipher_letter(item.first_letter);
    entry.b = cipher_letter(item.second_letter);
    entry.cmd = CMD_KEY;
    push = accept;
    unique case (item.op)
      OP_KEY: begin
        entry.a = fold_j(item.first_letter);
        // Letters above Z are ignored and never reach the back end.
        push = accept && (item.first_letter <= LETTER_Z);
      end
      OP_FINISH: entry.cmd = CMD_FINISH;
      OP_DECRYPT: entry.cmd = CMD_DECRYPT;
      OP_CLEAR: entry.cmd = CMD_CLEAR;
      default: entry.cmd = CMD_KEY;
    endcase
  end

endmodule

[rtl/core/pfd_queue.sv]
// Short command queue between the front and back ends.
module pfd_queue
  import pfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_word_t entry,
  input  logic      pop,
  output cmd_word_t head,
  output q_stat_t   q_stat
);

  cmd_word_t          slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign head = slots[rd_ptr];
  assign q_stat.valid = (count != '0);
  assign q_stat.full = (count == (QPTR_W + 1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/pfd_back.sv]
// Back end: builds the key square and decrypts cipher pairs from it.
module pfd_back
  import pfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_word_t head,
  input  q_stat_t   q_stat,
  output logic      pop,
  output logic      strobe,
  output out_word_t result
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FILL   = 4'b0010,
    S_LOOK   = 4'b0100,
    S_SQUARE = 4'b1000
  } state_t;

  state_t               state;
  logic [4:0]           square_mem [CELLS];
  logic [4:0]           place_mem [LETTERS];
  logic [LETTERS-1:0]   used;
  logic [4:0]           fill;
  logic [4:0]           walk;
  logic                 is_dec;
  logic [4:0]           let_a;
  logic [4:0]           let_b;
  logic [4:0]           p1;
  logic [4:0]           p2;
  logic                 place_en;
  logic [4:0]           place_l;
  logic                 place_ok;
  logic [2:0]           r1, c1, r2, c2;
  logic [2:0]           r1_new, c1_new, r2_new, c2_new;
  logic [4:0]           i1, i2;

  assign pop = (state == S_IDLE) && q_stat.valid;

  always_comb begin
    place_en = 1'b0;
    place_l = head.a;
    priority if (pop && (head.cmd == CMD_KEY)) begin
      place_en = 1'b1;
    end else if ((state == S_FILL) && (fill != CELL_COUNT) && (walk != LETTER_J)) begin
      place_en = 1'b1;
      place_l = walk;
    end else begin
      place_en = 1'b0;
    end
  end

  assign place_ok = place_en && !used[place_l] && (fill < CELL_COUNT);

  always_comb begin
    r1 = cell_row(p1);
    c1 = cell_col(p1);
    r2 = cell_row(p2);
    c2 = cell_col(p2);
    r1_new = r1;
    r2_new = r2;
    c1_new = c2;
    c2_new = c1;
    if (r1 == r2) begin
      c1_new = step_back(c1);
      c2_new = step_back(c2);
    end else if (c1 == c2) begin
      r1_new = step_back(r1);
      r2_new = step_back(r2);
      c1_new = c1;
      c2_new = c2;
    end
    i1 = cell_index(r1_new, c1_new);
    i2 = cell_index(r2_new, c2_new);
  end

  always_ff @(posedge clk) begin
    if (place_ok) begin
      square_mem[fill] <= place_l;
      place_mem[place_l] <= fill;
    end
    if (state == S_LOOK) begin
      p1 <= place_mem[let_a];
      p2 <= place_mem[let_b];
    end
    if (state == S_SQUARE) begin
      result.plain_first <= square_mem[i1];
      result.plain_second <= square_mem[i2];
    end
    if (pop) begin
      let_a <= head.a;
      let_b <= head.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      fill <= '0;
      walk <= '0;
      is_dec <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (place_ok) begin
        used[place_l] <= 1'b1;
        fill <= fill + 5'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            is_dec <= (head.cmd == CMD_DECRYPT);
            walk <= '0;
            unique case (head.cmd)
              CMD_KEY: state <= S_IDLE;
              CMD_FINISH, CMD_DECRYPT: state <= S_FILL;
              CMD_CLEAR: begin
                used <= '0;
                fill <= '0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_FILL: begin
          if (fill == CELL_COUNT) begin
            state <= is_dec ? S_LOOK : S_IDLE;
          end else begin
            walk <= walk + 5'd1;
          end
        end
        S_LOOK: state <= S_SQUARE;
        S_SQUARE: begin
          strobe <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/playfair_decrypt.sv]
// Top level of the Playfair decryption block with its on-chip key square.
//
// A word is taken at a rising edge where start is high and busy is low; the
// front end queues up to two words, and busy is high only while that queue
// is full. The back end runs one word at a time: a key letter or a clear
// is handled in the idle state, a finish walks the alphabet in the fill
// state, and a decrypt passes through the fill state, which finishes the
// square if needed, and then the look and square states. The walk through
// the alphabet, one letter per cycle into the single-write key square,
// sets how long a finish runs. The plaintext pair appears on result with
// strobe high for exactly one cycle, in the order the words were taken; the
// receiver cannot hold it off.
module playfair_decrypt
  import pfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_word_t  item,
  output logic      busy,
  output logic      strobe,
  output out_word_t result
);

  q_stat_t   q_stat;
  logic      push;
  logic      pop;
  cmd_word_t entry;
  cmd_word_t head;

  pfd_front u_front (
    .start  (start),
    .item   (item),
    .q_stat (q_stat),
    .busy   (busy),
    .push   (push),
    .entry  (entry)
  );

  pfd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .entry  (entry),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  pfd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

endmodule

[rtl/core/pfd_check.sv]
// Port-level checks for the Playfair decryption block and their binding.
module pfd_check
  import pfd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      strobe,
  input out_word_t result
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe && !busy)
    else $error("Strobe or busy high after reset.");

  a_strobe_gap: assert property (@(posedge clk) disable iff (rst) strobe |=> !strobe)
    else $error("Two results in consecutive cycles.");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("Busy rose without a word being taken.");

  a_result_known: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.plain_first <= LETTER_Z) && (result.plain_second <= LETTER_Z))
    else $error("Result letter out of range.");

endmodule

bind playfair_decrypt pfd_check u_pfd_check (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

[sim/testbench.sv]
// Self-checking testbench for playfair_decrypt: key, finish, clear and decrypt words against a predictor.
module testbench;
  import pfd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 120;
  localparam int TARGET_WORDS = 750;

  logic clk = 1'b0;
  logic rst;
  logic start;
  in_word_t item;
  logic busy;
  logic strobe;
  out_word_t result;

  logic [4:0] square_letter [CELLS];
  logic [4:0] letter_cell [LETTERS];
  logic [LETTERS-1:0] letter_taken = '0;
  int unsigned cells_filled = 0;
  out_word_t pending_pairs [$];

  int errors = 0;
  int words_sent = 0;
  int words_counted = 0;
  int pairs_checked = 0;
  int keys_started = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  playfair_decrypt dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .strobe(strobe),
    .result(result)
  );

  always #5 clk = ~clk;

  function automatic bit place_in_square(logic [4:0] l);
    if (l > LETTER_Z || letter_taken[l] || cells_filled >= CELLS) return 1'b0;
    square_letter[cells_filled] = l;
    letter_cell[l] = 5'(cells_filled);
    letter_taken[l] = 1'b1;
    cells_filled++;
    return 1'b1;
  endfunction

  function automatic bit complete_square();
    bit placed = 1'b0;
    for (int l = 0; l < LETTERS; l++) begin
      if (5'(l) != LETTER_J) placed |= place_in_square(5'(l));
    end
    return placed;
  endfunction

  function automatic logic [4:0] cipher_to_letter(logic [4:0] v);
    logic [4:0] l;
    l = (v > LETTER_Z) ? LETTER_Z : v;
    return (l == LETTER_J) ? LETTER_I : l;
  endfunction

  // Updates the key square copy and queues the plaintext pair a decrypt word produces.
  // Returns whether the word had any effect on the block.
  function automatic bit predict_word(in_word_t w);
    logic [4:0] a;
    logic [4:0] b;
    int r1, c1, r2, c2, t;
    bit effective;
    out_word_t pair;
    effective = 1'b0;
    case (w.op)
      OP_KEY: begin
        effective = place_in_square((w.first_letter == LETTER_J) ? LETTER_I : w.first_letter);
      end
      OP_FINISH: begin
        effective = complete_square();
      end
      OP_CLEAR: begin
        letter_taken = '0;
        cells_filled = 0;
        keys_started++;
        effective = 1'b1;
      end
      OP_DECRYPT: begin
        if (cells_filled < CELLS) void'(complete_square());
        a = cipher_to_letter(w.first_letter);
        b = cipher_to_letter(w.second_letter);
        r1 = letter_cell[a] / SIDE;
        c1 = letter_cell[a] % SIDE;
        r2 = letter_cell[b] / SIDE;
        c2 = letter_cell[b] % SIDE;
        if (r1 == r2) begin
          c1 = (c1 + SIDE - 1) % SIDE;
          c2 = (c2 + SIDE - 1) % SIDE;
        end else if (c1 == c2) begin
          r1 = (r1 + SIDE - 1) % SIDE;
          r2 = (r2 + SIDE - 1) % SIDE;
        end else begin
          t = c1;
          c1 = c2;
          c2 = t;
        end
        pair.plain_first = square_letter[r1 * SIDE + c1];
        pair.plain_second = square_letter[r2 * SIDE + c2];
        pending_pairs.push_back(pair);
        effective = 1'b1;
      end
    endcase
    return effective;
  endfunction

  function automatic in_word_t make_word(logic [1:0] op, logic [4:0] f, logic [4:0] s);
    in_word_t w;
    w.op = op;
    w.first_letter = f;
    w.second_letter = s;
    return w;
  endfunction

  // Mostly real letters, now and then a code above Z.
  function automatic logic [4:0] any_letter();
    if ($urandom_range(7) == 0) return 5'($urandom_range(31, 26));
    return 5'($urandom_range(25));
  endfunction

  task automatic send_word(in_word_t w);
    if (gaps_on && $urandom_range(99) < 36) begin
      start <= 1'b0;
      if ($urandom_range(9) == 0) repeat ($urandom_range(40, 10)) @(posedge clk);
      else repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    start <= 1'b1;
    item <= w;
    do @(posedge clk); while (busy);
    if (predict_word(w)) words_counted++;
    words_sent++;
  endtask

  // After reset the square is the plain alphabet, finished by the first decrypt.
  task automatic test_default_square();
    send_word(make_word(OP_DECRYPT, 5'd0, 5'd1));
    send_word(make_word(OP_DECRYPT, 5'd0, 5'd21));
    send_word(make_word(OP_DECRYPT, 5'd25, 5'd25));
    send_word(make_word(OP_DECRYPT, 5'd0, 5'd25));
  endtask

  task automatic test_key_rules();
    send_word(make_word(OP_CLEAR, 5'd0, 5'd31));
    send_word(make_word(OP_KEY, 5'd9, 5'd0));
    send_word(make_word(OP_KEY, 5'd8, 5'd31));
    send_word(make_word(OP_KEY, 5'd31, 5'd0));
    send_word(make_word(OP_KEY, 5'd26, 5'd0));
    send_word(make_word(OP_KEY, 5'd0, 5'd0));
    send_word(make_word(OP_KEY, 5'd0, 5'd0));
    send_word(make_word(OP_KEY, 5'd25, 5'd0));
    send_word(make_word(OP_FINISH, 5'd31, 5'd31));
    send_word(make_word(OP_KEY, 5'd1, 5'd0));
    send_word(make_word(OP_FINISH, 5'd0, 5'd0));
  endtask

  task automatic test_decrypt_cases();
    send_word(make_word(OP_DECRYPT, 5'd8, 5'd9));
    send_word(make_word(OP_DECRYPT, 5'd9, 5'd0));
    send_word(make_word(OP_DECRYPT, 5'd31, 5'd26));
    send_word(make_word(OP_DECRYPT, 5'd30, 5'd3));
  endtask

  // A clear keeps the old tables, so a decrypt right after it must refill everything.
  task automatic test_clear();
    send_word(make_word(OP_CLEAR, 5'd31, 5'd0));
    send_word(make_word(OP_DECRYPT, 5'd2, 5'd17));
    send_word(make_word(OP_CLEAR, 5'd0, 5'd0));
    send_word(make_word(OP_KEY, 5'd24, 5'd0));
    send_word(make_word(OP_KEY, 5'd23, 5'd0));
    send_word(make_word(OP_DECRYPT, 5'd24, 5'd23));
  endtask

  // Mostly complete key sessions with random content, plus stray words of any kind.
  task automatic test_random_sessions();
    int key_len;
    int pair_count;
    while (words_sent < TARGET_WORDS) begin
      gaps_on = !(words_sent >= 300 && words_sent < 420);
      if ($urandom_range(99) < 85) begin
        send_word(make_word(OP_CLEAR, 5'($urandom_range(31)), 5'($urandom_range(31))));
        key_len = $urandom_range(12);
        repeat (key_len) send_word(make_word(OP_KEY, any_letter(), 5'($urandom_range(31))));
        if ($urandom_range(1) == 1) begin
          send_word(make_word(OP_FINISH, 5'($urandom_range(31)), 5'($urandom_range(31))));
        end
        pair_count = $urandom_range(10, 1);
        repeat (pair_count) send_word(make_word(OP_DECRYPT, any_letter(), any_letter()));
      end else begin
        repeat ($urandom_range(6, 1)) begin
          send_word(make_word(2'($urandom_range(3)), 5'($urandom_range(31)),
                              5'($urandom_range(31))));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && strobe) begin
      if (pending_pairs.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %0d %0d", $time,
                 result.plain_first, result.plain_second);
      end else begin
        want = pending_pairs.pop_front();
        pairs_checked++;
        if (result.plain_first !== want.plain_first) begin
          errors++;
          $display("%0t: plain_first expected %0d, actual %0d", $time,
                   want.plain_first, result.plain_first);
        end
        if (result.plain_second !== want.plain_second) begin
          errors++;
          $display("%0t: plain_second expected %0d, actual %0d", $time,
                   want.plain_second, result.plain_second);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d pairs still outstanding", $time, pending_pairs.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_default_square();
    test_key_rules();
    test_decrypt_cases();
    test_clear();
    test_random_sessions();
    start <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words (%0d changed the key state or decrypted) over %0d key sessions.",
             words_sent, words_counted, keys_started);
    $display("Checked %0d plaintext pairs.", pairs_checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
